FILE: rtl/pas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pas_pkg: shared types and constants of the priority aging scheduler
// slot count, priority range, command codes and the slot table entry
// ----------------------------------------------------------------------------
package pas_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W     = $clog2(TASK_SLOTS);

  typedef logic signed [5:0] prio_t;

  localparam prio_t PRIO_MIN  = -6'sd20;
  localparam prio_t PRIO_MAX  = 6'sd20;
  localparam prio_t STEP_RST  = -6'sd1;

  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SCHED  = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  // one slot table word
  typedef struct packed {
    prio_t sta;
    prio_t dyn;
  } entry_t;

endpackage

FILE: rtl/priority_aging_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_aging_scheduler: slot table scheduler with priority aging
// set / remove / query address one slot, schedule scans every slot
// ----------------------------------------------------------------------------
// sequence: set goes from ST_IDLE to ST_PUT; remove and query pass ST_LOOK
// before ST_PUT; schedule runs ST_SCAN over every slot, then ST_FIX, ST_PUT
// throughput: one command at a time, in_ready is low until ST_PUT hands the
// result to a free output register; the scan reads one table word per cycle
// reset: ready flags and written flags clear at once, aging_step = -1; no
// clearing pass, a never-written slot reads as zero priorities
// ----------------------------------------------------------------------------
module priority_aging_scheduler (
  input  logic              clk,
  input  logic              rst_n,
  // command beats
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  input  logic [3:0]        in_task_slot,
  input  logic signed [7:0] in_new_priority,
  // result beats
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_found,
  output logic [3:0]        out_chosen_slot,
  output logic signed [5:0] out_static_priority,
  output logic signed [5:0] out_dynamic_priority,
  // aging step register
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic signed [5:0] cfg_data
);

  localparam int SW = pas_pkg::SLOT_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(pas_pkg::TASK_SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_FIX,
    ST_PUT
  } state_t;

  // clamp to the priority range
  function automatic pas_pkg::prio_t clamp_prio(input logic signed [7:0] v);
    pas_pkg::prio_t r;
    if (v < 8'(pas_pkg::PRIO_MIN)) begin
      r = pas_pkg::PRIO_MIN;
    end else if (v > 8'(pas_pkg::PRIO_MAX)) begin
      r = pas_pkg::PRIO_MAX;
    end else begin
      r = v[5:0];
    end
    return r;
  endfunction

  // table index from the four-bit slot field
  function automatic logic [SW-1:0] slot_idx(input logic [3:0] s);
    logic [SW+3:0] w;
    w = {{SW{1'b0}}, s};
    return w[SW-1:0];
  endfunction

  // four-bit slot field from a table index
  function automatic logic [3:0] slot_field(input logic [SW-1:0] i);
    logic [SW+3:0] w;
    w = {4'd0, i};
    return w[3:0];
  endfunction

  state_t                  state_r;
  logic [pas_pkg::TASK_SLOTS-1:0] ready_r;
  logic [pas_pkg::TASK_SLOTS-1:0] written_r;   // slot table word holds data
  pas_pkg::prio_t          step_r;

  // slot table memory, one read port with registered data, one write port
  pas_pkg::entry_t         mem [pas_pkg::TASK_SLOTS];
  pas_pkg::entry_t         rdata_r;
  logic [SW-1:0]           rd_idx_r;           // index behind rdata_r
  logic [SW-1:0]           rd_addr;
  logic                    mem_we;
  logic [SW-1:0]           mem_waddr;
  pas_pkg::entry_t         mem_wdata;

  // command in flight
  logic                    slot_ok_r;
  logic                    any_r;
  logic [SW-1:0]           best_r;
  pas_pkg::prio_t          best_dyn_r;
  pas_pkg::prio_t          best_sta_r;

  // finished result, waiting for the output register
  logic                    res_found_r;
  logic [3:0]              res_slot_r;
  pas_pkg::prio_t          res_sta_r;
  pas_pkg::prio_t          res_dyn_r;

  logic                    out_valid_r;
  logic                    out_found_r;
  logic [3:0]              out_slot_r;
  pas_pkg::prio_t          out_sta_r;
  pas_pkg::prio_t          out_dyn_r;

  logic                    in_fire;
  logic                    slot_ok;
  logic [SW-1:0]           in_idx;
  pas_pkg::prio_t          set_prio;
  pas_pkg::prio_t          aged_dyn;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // slots at or beyond the table size are ignored by set, remove and query
  assign slot_ok   = {28'd0, in_task_slot} < 32'(pas_pkg::TASK_SLOTS);
  assign in_idx    = slot_idx(in_task_slot);
  assign set_prio  = clamp_prio(in_new_priority);

  // aging of the word under scan, saturating at both ends
  assign aged_dyn  = clamp_prio({{2{rdata_r.dyn[5]}}, rdata_r.dyn}
                              + {{2{step_r[5]}}, step_r});

  // memory address and write control
  always_comb begin
    rd_addr   = rd_idx_r;
    mem_we    = 1'b0;
    mem_waddr = rd_idx_r;
    mem_wdata = rdata_r;
    case (state_r)
      ST_IDLE: begin
        // schedule starts its scan at slot zero
        rd_addr = (in_cmd == pas_pkg::CMD_SCHED) ? '0 : in_idx;
        if (in_fire && (in_cmd == pas_pkg::CMD_SET) && slot_ok) begin
          mem_we    = 1'b1;
          mem_waddr = in_idx;
          mem_wdata = '{sta: set_prio, dyn: set_prio};
        end
      end
      ST_SCAN: begin
        // read slot i+1 while slot i is aged and written back
        rd_addr = rd_idx_r + SW'(1);
        if (ready_r[rd_idx_r]) begin
          mem_we    = 1'b1;
          mem_waddr = rd_idx_r;
          mem_wdata = '{sta: rdata_r.sta, dyn: aged_dyn};
        end
      end
      ST_FIX: begin
        // picked slot drops back to its static priority
        if (any_r) begin
          mem_we    = 1'b1;
          mem_waddr = best_r;
          mem_wdata = '{sta: best_sta_r, dyn: best_sta_r};
        end
      end
      default: begin
        rd_addr = rd_idx_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r  <= mem[rd_addr];
    rd_idx_r <= rd_addr;
  end

  // control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ready_r     <= '0;
      written_r   <= '0;
      step_r      <= pas_pkg::STEP_RST;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        step_r <= cfg_data;
      end
      // a result handed over in ST_PUT refills the output register instead
      if (out_valid_r && out_ready && (state_r != ST_PUT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            slot_ok_r   <= slot_ok;
            res_found_r <= (in_cmd == pas_pkg::CMD_QUERY) && slot_ok && ready_r[in_idx];
            res_slot_r  <= in_task_slot;
            res_sta_r   <= ((in_cmd == pas_pkg::CMD_SET) && slot_ok) ? set_prio : '0;
            res_dyn_r   <= ((in_cmd == pas_pkg::CMD_SET) && slot_ok) ? set_prio : '0;
            any_r       <= 1'b0;
            case (in_cmd)
              pas_pkg::CMD_SET: begin
                if (slot_ok) begin
                  ready_r[in_idx]   <= 1'b1;
                  written_r[in_idx] <= 1'b1;
                end
                state_r <= ST_PUT;
              end
              pas_pkg::CMD_REMOVE: begin
                if (slot_ok) begin
                  ready_r[in_idx] <= 1'b0;
                end
                state_r <= ST_LOOK;
              end
              pas_pkg::CMD_QUERY: begin
                state_r <= ST_LOOK;
              end
              default: begin
                // schedule
                state_r <= ST_SCAN;
              end
            endcase
          end
        end

        ST_LOOK: begin
          // stored priorities of the addressed slot
          if (slot_ok_r && written_r[rd_idx_r]) begin
            res_sta_r <= rdata_r.sta;
            res_dyn_r <= rdata_r.dyn;
          end
          state_r <= ST_PUT;
        end

        ST_SCAN: begin
          // lowest dynamic priority wins, a later slot wins a tie
          if (ready_r[rd_idx_r]) begin
            any_r <= 1'b1;
            if (!any_r || (rdata_r.dyn <= best_dyn_r)) begin
              best_r     <= rd_idx_r;
              best_dyn_r <= rdata_r.dyn;
              best_sta_r <= rdata_r.sta;
            end
          end
          if (rd_idx_r == LAST_SLOT) begin
            state_r <= ST_FIX;
          end
        end

        ST_FIX: begin
          if (any_r) begin
            res_found_r <= 1'b1;
            res_slot_r  <= slot_field(best_r);
            res_sta_r   <= best_sta_r;
            res_dyn_r   <= best_sta_r;
          end else begin
            res_slot_r  <= '0;
          end
          state_r <= ST_PUT;
        end

        ST_PUT: begin
          // hand the result over once the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_found_r <= res_found_r;
            out_slot_r  <= res_slot_r;
            out_sta_r   <= res_sta_r;
            out_dyn_r   <= res_dyn_r;
            state_r     <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_found            = out_found_r;
  assign out_chosen_slot      = out_slot_r;
  assign out_static_priority  = out_sta_r;
  assign out_dynamic_priority = out_dyn_r;

endmodule
